// File: rtl/core/crt_pkg.sv
// shared constants and types for the chunk reassembly table
`timescale 1ns / 1ps

package crt_pkg;

  localparam int SLOTS      = 4;
  localparam int MAX_PARTS  = 4;
  localparam int PART_BYTES = 16;
  localparam int HDR_LEN    = 6;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDX_W  = $clog2(MAX_PARTS);
  localparam int OFS_W  = $clog2(PART_BYTES);
  localparam int TOT_W  = $clog2(MAX_PARTS + 1);
  localparam int LEN_W  = $clog2(PART_BYTES + 1);
  localparam int POS_W  = $clog2(HDR_LEN + PART_BYTES + 1);
  localparam int CNT_W  = $clog2(MAX_PARTS * PART_BYTES + 1);

  localparam int STORE_AW = SLOT_W + IDX_W + OFS_W;
  localparam int LEN_AW   = SLOT_W + IDX_W;

  localparam logic [POS_W-1:0] POS_HDR  = POS_W'(HDR_LEN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(HDR_LEN - 1);
  localparam logic [POS_W-1:0] POS_MAX  = POS_W'(HDR_LEN + PART_BYTES);
  localparam logic [7:0]       BYTE_MASK = 8'hff;
  localparam logic [31:0]      TIMEOUT_RST = 32'd5000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_LEN_RD,
    ST_LEN_ACC,
    ST_BYTE_RD,
    ST_BYTE_OUT,
    ST_EMPTY
  } crt_state_t;

endpackage

// File: rtl/core/chunk_reassembly_table_top.sv
// chunk reassembly table: slot table, part memories and emission sequencer
//
// input channel (in_valid/in_ready): one transaction per frame byte (in_cmd = 0)
// or per expiry tick (in_cmd = 1). frames carry a 6-byte header (le id, part
// index, part count) then payload, cut to 16 bytes per part.
// in_ready is high while no message drains.
// when the last part of a message arrives, all its bytes leave on the result
// channel (out_valid/out_ready) in part order, one per transaction, with
// out_msg_last on the final one. draining first sums the part lengths (a read
// state then an add state per part), then per part a length read state then an
// accept state, and per byte a read state then an output state, as the part memories read registered.
// an empty message gives one transaction with out_byte_valid low.
// cfg_wr_en loads the timeout in ms; reset gives 5000 and frees all slots.
// the part memories need no clearing, so no dead time after reset.
// a stalled receiver holds the output register; the sequencer waits on it,
// while a new input transaction may be taken with the last result still held.
`timescale 1ns / 1ps

module chunk_reassembly_table_top
  import crt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_msg_byte,
  output logic        out_byte_valid,
  output logic        out_msg_last,
  output logic [31:0] out_msg_ident
);

  // slot table
  logic                 slot_used_r [SLOTS];
  logic                 slot_used_nxt [SLOTS];
  logic [31:0]          slot_id_r [SLOTS];
  logic [31:0]          slot_id_nxt [SLOTS];
  logic [TOT_W-1:0]     slot_tot_r [SLOTS];
  logic [TOT_W-1:0]     slot_tot_nxt [SLOTS];
  logic [31:0]          slot_time_r [SLOTS];
  logic [31:0]          slot_time_nxt [SLOTS];
  logic [MAX_PARTS-1:0] slot_rcv_r [SLOTS];
  logic [MAX_PARTS-1:0] slot_rcv_nxt [SLOTS];

  logic [31:0] timeout_r;

  // frame parser
  logic [47:0]       hdr_r, hdr_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [SLOT_W-1:0] tgt_r, tgt_nxt;
  logic              rej_r, rej_nxt;

  // emission sequencer
  crt_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0] em_slot_r, em_slot_nxt;
  logic [31:0]       em_id_r, em_id_nxt;
  logic [TOT_W-1:0]  em_tot_r, em_tot_nxt;
  logic [TOT_W-1:0]  part_r, part_nxt;
  logic [OFS_W-1:0]  ofs_r, ofs_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_bv_r, out_bv_nxt;
  logic        out_last_r, out_last_nxt;
  logic [31:0] out_id_r, out_id_nxt;

  // memories
  logic [7:0]       part_mem [2**STORE_AW];
  logic [LEN_W-1:0] len_mem [2**LEN_AW];
  logic                store_we, len_we;
  logic [STORE_AW-1:0] store_waddr, store_raddr;
  logic [LEN_AW-1:0]   len_waddr, len_raddr;
  logic [LEN_W-1:0]    len_wdata;
  logic [7:0]          store_q_r;
  logic [LEN_W-1:0]    len_q_r;

  logic out_free;

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_msg_byte   = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_msg_last   = out_last_r;
  assign out_msg_ident  = out_id_r;
  assign out_free       = !out_valid_r || out_ready;

  assign store_raddr = {em_slot_r, part_r[IDX_W-1:0], ofs_r};
  assign len_raddr   = {em_slot_r, part_r[IDX_W-1:0]};

  always_comb begin
    logic [47:0]      hdr_full;
    logic [7:0]       h_idx, h_cnt;
    logic             found;
    logic [POS_W-1:0] pos_inc;
    logic [SLOT_W-1:0] s;
    logic [IDX_W-1:0] pidx;
    logic [MAX_PARTS-1:0] rcv_new;
    logic             all_in;

    hdr_full = '0;
    h_idx    = '0;
    h_cnt    = '0;
    found    = 1'b0;
    pos_inc  = pos_r;
    s        = '0;
    pidx     = '0;
    rcv_new  = '0;
    all_in   = 1'b0;

    for (int i = 0; i < SLOTS; i++) begin
      slot_used_nxt[i] = slot_used_r[i];
      slot_id_nxt[i]   = slot_id_r[i];
      slot_tot_nxt[i]  = slot_tot_r[i];
      slot_time_nxt[i] = slot_time_r[i];
      slot_rcv_nxt[i]  = slot_rcv_r[i];
    end
    hdr_nxt = hdr_r;
    pos_nxt = pos_r;
    tgt_nxt = tgt_r;
    rej_nxt = rej_r;

    state_nxt   = state_r;
    em_slot_nxt = em_slot_r;
    em_id_nxt   = em_id_r;
    em_tot_nxt  = em_tot_r;
    part_nxt    = part_r;
    ofs_nxt     = ofs_r;
    len_nxt     = len_r;
    total_nxt   = total_r;
    remain_nxt  = remain_r;

    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_last_nxt  = out_last_r;
    out_id_nxt    = out_id_r;

    store_we    = 1'b0;
    store_waddr = {tgt_r, hdr_r[32 +: IDX_W], OFS_W'(pos_r - POS_HDR)};
    len_we      = 1'b0;
    len_waddr   = '0;
    len_wdata   = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_used_r[i] && (32'(in_now_ms - slot_time_r[i]) > timeout_r)) begin
                slot_used_nxt[i] = 1'b0;
                slot_rcv_nxt[i]  = '0;
              end
            end
          end else begin
            if (!rej_r) begin
              if (pos_r < POS_HDR) begin
                hdr_nxt[pos_r*8 +: 8] = in_data_byte;
                if (pos_r == POS_LAST) begin
                  hdr_full = hdr_nxt;
                  h_idx    = hdr_full[39:32];
                  h_cnt    = hdr_full[47:40];
                  if (h_cnt == 8'd0 || h_idx >= h_cnt || h_cnt > 8'(MAX_PARTS)) begin
                    rej_nxt = 1'b1;
                  end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                      if (!found && slot_used_r[i] && slot_id_r[i] == hdr_full[31:0] &&
                          slot_tot_r[i] == h_cnt[TOT_W-1:0]) begin
                        found            = 1'b1;
                        tgt_nxt          = SLOT_W'(i);
                        slot_time_nxt[i] = in_now_ms;
                      end
                    end
                    for (int i = 0; i < SLOTS; i++) begin
                      if (!found && !slot_used_r[i]) begin
                        found            = 1'b1;
                        tgt_nxt          = SLOT_W'(i);
                        slot_used_nxt[i] = 1'b1;
                        slot_id_nxt[i]   = hdr_full[31:0];
                        slot_tot_nxt[i]  = h_cnt[TOT_W-1:0];
                        slot_time_nxt[i] = in_now_ms;
                        slot_rcv_nxt[i]  = '0;
                      end
                    end
                    if (!found) begin
                      rej_nxt = 1'b1;
                    end
                  end
                end
              end else if (pos_r < POS_MAX) begin
                store_we = 1'b1;
              end
            end
            if (pos_r < POS_MAX) begin
              pos_inc = pos_r + POS_W'(1);
            end
            pos_nxt = pos_inc;

            if (in_frame_end) begin
              s    = tgt_nxt;
              pidx = hdr_nxt[32 +: IDX_W];
              if (!rej_nxt && pos_inc >= POS_HDR && slot_used_nxt[s]) begin
                len_we    = 1'b1;
                len_waddr = {s, pidx};
                len_wdata = LEN_W'(pos_inc - POS_HDR);
                rcv_new   = slot_rcv_nxt[s];
                rcv_new[pidx] = 1'b1;
                slot_rcv_nxt[s]  = rcv_new;
                slot_time_nxt[s] = in_now_ms;
                all_in = 1'b1;
                for (int p = 0; p < MAX_PARTS; p++) begin
                  if (TOT_W'(p) < slot_tot_nxt[s] && !rcv_new[p]) begin
                    all_in = 1'b0;
                  end
                end
                if (all_in) begin
                  // slot is released now, its id and part count live on in the em_* registers
                  em_slot_nxt      = s;
                  em_id_nxt        = slot_id_nxt[s];
                  em_tot_nxt       = slot_tot_nxt[s];
                  part_nxt         = '0;
                  total_nxt        = '0;
                  slot_used_nxt[s] = 1'b0;
                  slot_rcv_nxt[s]  = '0;
                  state_nxt        = ST_SUM_RD;
                end
              end
              hdr_nxt = '0;
              pos_nxt = '0;
              tgt_nxt = '0;
              rej_nxt = 1'b0;
            end
          end
        end
      end

      ST_SUM_RD: begin
        if (part_r == em_tot_r) begin
          part_nxt   = '0;
          remain_nxt = total_r;
          state_nxt  = (total_r == '0) ? ST_EMPTY : ST_LEN_RD;
        end else begin
          state_nxt = ST_SUM_ACC;
        end
      end

      ST_SUM_ACC: begin
        total_nxt = total_r + CNT_W'(len_q_r);
        part_nxt  = part_r + TOT_W'(1);
        state_nxt = ST_SUM_RD;
      end

      ST_LEN_RD: begin
        state_nxt = ST_LEN_ACC;
      end

      ST_LEN_ACC: begin
        len_nxt = len_q_r;
        ofs_nxt = '0;
        if (len_q_r == '0) begin
          part_nxt  = part_r + TOT_W'(1);
          state_nxt = ST_LEN_RD;
        end else begin
          state_nxt = ST_BYTE_RD;
        end
      end

      ST_BYTE_RD: begin
        if (out_free) begin
          state_nxt = ST_BYTE_OUT;
        end
      end

      ST_BYTE_OUT: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = store_q_r;
        out_bv_nxt    = 1'b1;
        out_last_nxt  = (remain_r == CNT_W'(1));
        out_id_nxt    = em_id_r;
        remain_nxt    = remain_r - CNT_W'(1);
        if (LEN_W'(ofs_r) == len_r - LEN_W'(1)) begin
          part_nxt  = part_r + TOT_W'(1);
          state_nxt = (remain_r == CNT_W'(1)) ? ST_IDLE : ST_LEN_RD;
        end else begin
          ofs_nxt   = ofs_r + OFS_W'(1);
          state_nxt = ST_BYTE_RD;
        end
      end

      ST_EMPTY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = '0;
          out_bv_nxt    = 1'b0;
          out_last_nxt  = 1'b1;
          out_id_nxt    = em_id_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      hdr_r       <= '0;
      pos_r       <= '0;
      tgt_r       <= '0;
      rej_r       <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_used_r[i] <= 1'b0;
        slot_id_r[i]   <= '0;
        slot_tot_r[i]  <= '0;
        slot_time_r[i] <= '0;
        slot_rcv_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      hdr_r <= hdr_nxt;
      pos_r <= pos_nxt;
      tgt_r <= tgt_nxt;
      rej_r <= rej_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        slot_used_r[i] <= slot_used_nxt[i];
        slot_id_r[i]   <= slot_id_nxt[i];
        slot_tot_r[i]  <= slot_tot_nxt[i];
        slot_time_r[i] <= slot_time_nxt[i];
        slot_rcv_r[i]  <= slot_rcv_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    em_slot_r  <= em_slot_nxt;
    em_id_r    <= em_id_nxt;
    em_tot_r   <= em_tot_nxt;
    part_r     <= part_nxt;
    ofs_r      <= ofs_nxt;
    len_r      <= len_nxt;
    total_r    <= total_nxt;
    remain_r   <= remain_nxt;
    out_byte_r <= out_byte_nxt;
    out_bv_r   <= out_bv_nxt;
    out_last_r <= out_last_nxt;
    out_id_r   <= out_id_nxt;
  end

  // part payload memory
  always_ff @(posedge clk) begin
    if (store_we) begin
      part_mem[store_waddr] <= in_data_byte & BYTE_MASK;
    end
    store_q_r <= part_mem[store_raddr];
  end

  // part length memory
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_q_r <= len_mem[len_raddr];
  end

`ifndef SYNTHESIS
  // the draining slot was released when its last part arrived
  a_em_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !slot_used_r[em_slot_r])
    else $error("draining slot still marked used");

  a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BYTE_OUT || state_r == ST_BYTE_RD) |-> (remain_r != '0))
    else $error("byte emitted past message total");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BYTE_OUT) |-> (len_r != '0 && len_r <= LEN_W'(PART_BYTES)))
    else $error("part length out of range");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("frame position beyond saturation");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BYTE_OUT && remain_r == CNT_W'(1)) |=> (state_r == ST_IDLE && out_msg_last))
    else $error("final byte did not end the message");
`endif

endmodule
